### rtl/table_rsqrt_sqrt_newton_defines.svh
// -----------------------------------------------------------------------------
// table_rsqrt_sqrt_newton_defines.svh
// Assertion macros shared by the checkers of the square root block.
// -----------------------------------------------------------------------------
`ifndef TABLE_RSQRT_SQRT_NEWTON_DEFINES_SVH
`define TABLE_RSQRT_SQRT_NEWTON_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define TRSN_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked after the delay given by dly.
`define TRSN_ASSERT_DLY(label, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##(dly) (cons)) \
		else $error(msg);

`endif

### rtl/trsn_pkg.sv
// -----------------------------------------------------------------------------
// trsn_pkg
// Types, constants and float helper functions of the square root block.
// -----------------------------------------------------------------------------
`default_nettype none

package trsn_pkg;

	// Clock edges from the edge that accepts an item to the edge that takes
	// its result.
	localparam int LATENCY = 23;

	// Float constants of the Newton step, the float units and the tables.
	localparam logic [31:0] FP_HALF         = 32'h3F00_0000;
	localparam logic [31:0] FP_THREE_HALVES = 32'h3FC0_0000;
	localparam logic [31:0] FP_DEFAULT_NAN  = 32'hFFC0_0000;
	localparam logic [31:0] FP_QUIET_BIT    = 32'h0040_0000;
	localparam logic [7:0]  EXP_ALL_ONES    = 8'hFF;
	localparam logic [22:0] SQRT_HALF_MANT  = 23'h3504F3;

	// Bit positions of the float fields.
	localparam int EXP_LSB  = 23;
	localparam int MANT_IDX = 13;

	// Operand before normalization: value = sig / 2^95 * 2^(ex - 127).
	typedef struct packed {
		logic               sign;
		logic [95:0]        sig;
		logic signed [11:0] ex;
		logic               special;
		logic [31:0]        spec_bits;
	} norm_t;

	// Operand with its normalizing shift already worked out.
	typedef struct packed {
		logic        sign;
		logic [95:0] sig;
		logic        left;
		logic [6:0]  amt;
		logic [7:0]  e_field;
		logic        ovf;
		logic        is_zero;
		logic        special;
		logic [31:0] spec_bits;
	} shift_t;

	// Leading zero count of a 96-bit word.
	function automatic logic [6:0] lzc96(logic [95:0] w);
		logic [6:0] cnt;
		cnt = 7'd0;
		for (int i = 0; i < 96; i++) begin
			if (w[i]) begin
				cnt = 7'(95 - i);
			end
		end
		return cnt;
	endfunction

	// Picks the shift that normalizes the word, or denormalizes it when the
	// exponent falls below the normal range.
	function automatic shift_t norm_prep(norm_t n);
		shift_t             s;
		logic [6:0]         lz;
		logic signed [11:0] e_r;
		lz = lzc96(n.sig);
		e_r = n.ex - $signed({5'd0, lz});
		s.sign = n.sign;
		s.sig = n.sig;
		s.special = n.special;
		s.spec_bits = n.spec_bits;
		s.is_zero = (n.sig == '0);
		s.ovf = 1'b0;
		s.left = 1'b1;
		s.amt = lz;
		s.e_field = e_r[7:0];
		if (e_r > 12'sd254) begin
			s.ovf = 1'b1;
		end else if (e_r < 12'sd1) begin
			s.e_field = 8'd0;
			if (n.ex >= 12'sd1) begin
				s.left = 1'b1;
				s.amt = 7'(n.ex - 12'sd1);
			end else begin
				s.left = 1'b0;
				s.amt = 7'(12'sd1 - n.ex);
			end
		end
		return s;
	endfunction

	// Shifts, rounds to nearest even and packs the float result.
	function automatic logic [31:0] norm_finish(shift_t s);
		logic [95:0] ws;
		logic        lost;
		logic        guard;
		logic        sticky;
		logic        rnd;
		logic [30:0] pk;
		logic [31:0] res;
		ws = s.left ? (s.sig << s.amt) : (s.sig >> s.amt);
		lost = !s.left && ((ws << s.amt) != s.sig);
		guard = ws[71];
		sticky = (|ws[70:0]) | lost;
		rnd = guard & (sticky | ws[72]);
		pk = {s.e_field, ws[94:72]} + 31'(rnd);
		if (s.special) begin
			res = s.spec_bits;
		end else if (s.is_zero) begin
			res = {s.sign, 31'd0};
		end else if (s.ovf) begin
			res = {s.sign, EXP_ALL_ONES, 23'd0};
		end else begin
			res = {s.sign, pk};
		end
		return res;
	endfunction

	// Exponent table entry: 1/sqrt(2^(e-127)), with the end codes clamped.
	function automatic logic [31:0] exp_rom_bits(logic [7:0] e);
		logic [7:0]        ee;
		logic signed [9:0] d;
		logic signed [9:0] k;
		logic [9:0]        field;
		logic [22:0]       mant;
		if (e == 8'd0) begin
			ee = 8'd1;
		end else if (e == EXP_ALL_ONES) begin
			ee = 8'd254;
		end else begin
			ee = e;
		end
		d = $signed({2'd0, ee}) - 10'sd127;
		if (d[0] == 1'b0) begin
			k = d >>> 1;
			field = 10'(10'sd127 - k);
			mant = 23'd0;
		end else begin
			k = (d - 10'sd1) >>> 1;
			field = 10'(10'sd126 - k);
			mant = SQRT_HALF_MANT;
		end
		return {1'b0, field[7:0], mant};
	endfunction

	// Widens a positive normal float to a real.
	function automatic real f32_to_real(logic [31:0] b);
		logic [63:0] d;
		if (b[30:0] == 31'd0) begin
			d = 64'd0;
		end else begin
			d = {b[31], 11'({3'd0, b[30:23]} + 11'd896), b[22:0], 29'd0};
		end
		return $bitstoreal(d);
	endfunction

	// Rounds a positive normal real to float bits, nearest even.
	function automatic logic [31:0] real_to_f32(real r);
		logic [63:0] d;
		logic [10:0] e64;
		logic [30:0] pk;
		logic        rnd;
		logic [31:0] res;
		d = $realtobits(r);
		e64 = d[62:52];
		pk = {8'(e64 - 11'd896), d[51:29]};
		rnd = d[28] & ((|d[27:0]) | d[29]);
		if (d[62:0] == 63'd0) begin
			res = 32'd0;
		end else begin
			res = {d[63], pk + 31'(rnd)};
		end
		return res;
	endfunction

	// Rounds a real to float precision and back.
	function automatic real f32_round(real r);
		return f32_to_real(real_to_f32(r));
	endfunction

	// Mantissa table entry: 1/sqrt(1 + i*step), refined in double precision.
	// The step is the reciprocal of the table depth.
	function automatic logic [31:0] man_rom_bits(int i, real step_raw);
		real step;
		real t;
		real x;
		real y;
		step = f32_round(step_raw);
		t = f32_round(step * real'(i));
		x = f32_round(1.0 + t);
		y = 0.85;
		for (int k = 0; k < 10; k++) begin
			y = y * (1.5 - 0.5 * x * y * y);
		end
		return real_to_f32(y);
	endfunction

endpackage

`default_nettype wire

### rtl/table_rsqrt_sqrt_newton.sv
// -----------------------------------------------------------------------------
// table_rsqrt_sqrt_newton
// Single-precision reciprocal square root or square root from a table guess
// refined by one Newton step.
// -----------------------------------------------------------------------------
// The block takes one item per clock cycle and never raises busy. Each item's
// result appears on result_bits, flagged by a one-cycle done pulse that the
// receiver cannot delay, and is valid while done is high. The result passes
// the table read register, a chain of seven dependent float operations (six
// multiplies and one subtract) of three register stages each, and the output
// register. A negative sample gives +0.0; -0.0 and NaN samples go through the
// datapath.
`default_nettype none

module table_rsqrt_sqrt_newton #(
	parameter int MANTISSA_TABLE_DEPTH = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        op,
	input  wire logic [31:0] sample_bits,
	output logic             done,
	output logic      [31:0] result_bits
);

	localparam int MIDX_W = $clog2(MANTISSA_TABLE_DEPTH);
	localparam int PROD_W = trsn_pkg::EXP_LSB + $clog2(MANTISSA_TABLE_DEPTH + 1);
	localparam real MAN_STEP = 1.0 / real'(MANTISSA_TABLE_DEPTH);

	typedef logic [31:0] man_tab_t [MANTISSA_TABLE_DEPTH];

	// Mantissa table contents, worked out at elaboration.
	function automatic man_tab_t build_man_tab();
		man_tab_t tab;
		for (int i = 0; i < MANTISSA_TABLE_DEPTH; i++) begin
			tab[i] = trsn_pkg::man_rom_bits(i, MAN_STEP);
		end
		return tab;
	endfunction

	localparam man_tab_t MAN_TAB = build_man_tab();

	logic              accept;
	logic              neg_in;
	logic [PROD_W-1:0] midx_prod;
	logic [MIDX_W-1:0] midx;

	logic              vld_s1, op_s1, neg_s1;
	logic [31:0]       f_s1, e_s1, m_s1;
	logic [31:0]       g_s4, h1_s7, a_s7, h2_s10, h3_s13, h4_s16, r_s19, res_s22;

	logic [31:0]       g_line_q [6];
	logic [31:0]       f_line_q [18];
	logic [31:0]       a_line_q [9];
	logic [31:0]       r_line_q [3];
	logic              vld_line_q [21];
	logic              op_line_q [21];
	logic              neg_line_q [21];

	logic              done_q;
	logic [31:0]       result_q;

	assign busy = 1'b0;
	assign accept = start && !busy;

	// A sample is below zero when its sign is set and it is neither zero nor NaN.
	assign neg_in = sample_bits[31] && (sample_bits[30:0] != 31'd0)
		&& !((sample_bits[30:23] == trsn_pkg::EXP_ALL_ONES) && (sample_bits[22:0] != 23'd0));

	// Mantissa table index: top mantissa bits scaled to the table depth.
	assign midx_prod = PROD_W'(sample_bits[22:0]) * PROD_W'(MANTISSA_TABLE_DEPTH);
	assign midx = midx_prod[trsn_pkg::EXP_LSB +: MIDX_W];

	// Stage 1 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	// Stage 1 payload: both table reads and the sample itself.
	always_ff @(posedge clk) begin
		op_s1 <= op;
		neg_s1 <= neg_in;
		f_s1 <= sample_bits;
		e_s1 <= trsn_pkg::exp_rom_bits(sample_bits[30:23]);
		m_s1 <= MAN_TAB[midx];
	end

	// Guess g and the Newton step.
	trsn_fpmul u_mul_g (.clk(clk), .a(e_s1), .b(m_s1), .y(g_s4));
	trsn_fpmul u_mul_h1 (.clk(clk), .a(trsn_pkg::FP_HALF), .b(g_s4), .y(h1_s7));
	trsn_fpmul u_mul_a (.clk(clk), .a(trsn_pkg::FP_THREE_HALVES), .b(g_s4), .y(a_s7));
	trsn_fpmul u_mul_h2 (.clk(clk), .a(h1_s7), .b(g_line_q[2]), .y(h2_s10));
	trsn_fpmul u_mul_h3 (.clk(clk), .a(h2_s10), .b(g_line_q[5]), .y(h3_s13));
	trsn_fpmul u_mul_h4 (.clk(clk), .a(h3_s13), .b(f_line_q[11]), .y(h4_s16));
	trsn_fpsub u_sub_r (.clk(clk), .a(a_line_q[8]), .b(h4_s16), .y(r_s19));
	trsn_fpmul u_mul_res (.clk(clk), .a(f_line_q[17]), .b(r_s19), .y(res_s22));

	// Delay lines that keep operands aligned with the multiply chain.
	always_ff @(posedge clk) begin
		g_line_q[0] <= g_s4;
		for (int i = 1; i < 6; i++) begin
			g_line_q[i] <= g_line_q[i-1];
		end
		f_line_q[0] <= f_s1;
		for (int i = 1; i < 18; i++) begin
			f_line_q[i] <= f_line_q[i-1];
		end
		a_line_q[0] <= a_s7;
		for (int i = 1; i < 9; i++) begin
			a_line_q[i] <= a_line_q[i-1];
		end
		r_line_q[0] <= r_s19;
		for (int i = 1; i < 3; i++) begin
			r_line_q[i] <= r_line_q[i-1];
		end
		op_line_q[0] <= op_s1;
		neg_line_q[0] <= neg_s1;
		for (int i = 1; i < 21; i++) begin
			op_line_q[i] <= op_line_q[i-1];
			neg_line_q[i] <= neg_line_q[i-1];
		end
	end

	// Valid bits travel with the items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 21; i++) begin
				vld_line_q[i] <= 1'b0;
			end
			done_q <= 1'b0;
		end else begin
			vld_line_q[0] <= vld_s1;
			for (int i = 1; i < 21; i++) begin
				vld_line_q[i] <= vld_line_q[i-1];
			end
			done_q <= vld_line_q[20];
		end
	end

	// Output register: pick the operation, force zero for negative samples.
	always_ff @(posedge clk) begin
		if (neg_line_q[20]) begin
			result_q <= 32'd0;
		end else if (op_line_q[20]) begin
			result_q <= res_s22;
		end else begin
			result_q <= r_line_q[2];
		end
	end

	assign done = done_q;
	assign result_bits = result_q;

endmodule

`default_nettype wire

### rtl/trsn_fpmul.sv
// -----------------------------------------------------------------------------
// trsn_fpmul
// Single-precision multiplier, round to nearest even, subnormals kept.
// Three register stages: product, normalize count, shift and round.
// -----------------------------------------------------------------------------
`default_nettype none

module trsn_fpmul (
	input  wire logic        clk,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [31:0] y
);

	logic              sa, sb;
	logic [7:0]        ea, eb, ea_eff, eb_eff;
	logic [22:0]       fa, fb;
	logic              nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
	logic [47:0]       prod;
	trsn_pkg::norm_t   n_d;
	trsn_pkg::norm_t   n_s1;
	trsn_pkg::shift_t  sh_s2;
	logic [31:0]       y_s3;

	// Unpack both operands and classify them.
	assign sa = a[31];
	assign sb = b[31];
	assign ea = a[30:23];
	assign eb = b[30:23];
	assign fa = a[22:0];
	assign fb = b[22:0];
	assign nan_a = (ea == trsn_pkg::EXP_ALL_ONES) && (fa != 23'd0);
	assign nan_b = (eb == trsn_pkg::EXP_ALL_ONES) && (fb != 23'd0);
	assign inf_a = (ea == trsn_pkg::EXP_ALL_ONES) && (fa == 23'd0);
	assign inf_b = (eb == trsn_pkg::EXP_ALL_ONES) && (fb == 23'd0);
	assign zero_a = (a[30:0] == 31'd0);
	assign zero_b = (b[30:0] == 31'd0);
	assign ea_eff = (ea == 8'd0) ? 8'd1 : ea;
	assign eb_eff = (eb == 8'd0) ? 8'd1 : eb;
	assign prod = 48'({(ea != 8'd0), fa}) * 48'({(eb != 8'd0), fb});

	// Significand product and special operands.
	always_comb begin
		n_d.sign = sa ^ sb;
		n_d.sig = {prod, 48'd0};
		n_d.ex = $signed({4'd0, ea_eff}) + $signed({4'd0, eb_eff}) - 12'sd126;
		n_d.special = 1'b1;
		if (nan_a) begin
			n_d.spec_bits = a | trsn_pkg::FP_QUIET_BIT;
		end else if (nan_b) begin
			n_d.spec_bits = b | trsn_pkg::FP_QUIET_BIT;
		end else if ((inf_a && zero_b) || (zero_a && inf_b)) begin
			n_d.spec_bits = trsn_pkg::FP_DEFAULT_NAN;
		end else if (inf_a || inf_b) begin
			n_d.spec_bits = {sa ^ sb, trsn_pkg::EXP_ALL_ONES, 23'd0};
		end else if (zero_a || zero_b) begin
			n_d.spec_bits = {sa ^ sb, 31'd0};
		end else begin
			n_d.special = 1'b0;
			n_d.spec_bits = 32'd0;
		end
	end

	// Pipeline: product, shift count, rounded result.
	always_ff @(posedge clk) begin
		n_s1 <= n_d;
		sh_s2 <= trsn_pkg::norm_prep(n_s1);
		y_s3 <= trsn_pkg::norm_finish(sh_s2);
	end

	assign y = y_s3;

endmodule

`default_nettype wire

### rtl/trsn_fpsub.sv
// -----------------------------------------------------------------------------
// trsn_fpsub
// Single-precision subtractor y = a - b, round to nearest even.
// Three register stages: align and add, normalize count, shift and round.
// -----------------------------------------------------------------------------
`default_nettype none

module trsn_fpsub (
	input  wire logic        clk,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [31:0] y
);

	logic              sa, sb;
	logic [7:0]        ea, eb, ea_eff, eb_eff, e_diff;
	logic [22:0]       fa, fb;
	logic              nan_a, nan_b, inf_a, inf_b, swap, lost, sign_big, sign_small;
	logic [95:0]       big, small_op, aligned, total;
	trsn_pkg::norm_t   n_d;
	trsn_pkg::norm_t   n_s1;
	trsn_pkg::shift_t  sh_s2;
	logic [31:0]       y_s3;

	// Unpack; the subtrahend's sign is flipped for the addition.
	assign sa = a[31];
	assign sb = ~b[31];
	assign ea = a[30:23];
	assign eb = b[30:23];
	assign fa = a[22:0];
	assign fb = b[22:0];
	assign nan_a = (ea == trsn_pkg::EXP_ALL_ONES) && (fa != 23'd0);
	assign nan_b = (eb == trsn_pkg::EXP_ALL_ONES) && (fb != 23'd0);
	assign inf_a = (ea == trsn_pkg::EXP_ALL_ONES) && (fa == 23'd0);
	assign inf_b = (eb == trsn_pkg::EXP_ALL_ONES) && (fb == 23'd0);
	assign ea_eff = (ea == 8'd0) ? 8'd1 : ea;
	assign eb_eff = (eb == 8'd0) ? 8'd1 : eb;

	// Order by magnitude and align the smaller operand; bits shifted out
	// collapse into the lowest bit, far below the rounding position.
	assign swap = (b[30:0] > a[30:0]);
	assign big = swap ? {1'b0, (eb != 8'd0), fb, 71'd0} : {1'b0, (ea != 8'd0), fa, 71'd0};
	assign small_op = swap ? {1'b0, (ea != 8'd0), fa, 71'd0} : {1'b0, (eb != 8'd0), fb, 71'd0};
	assign e_diff = swap ? (eb_eff - ea_eff) : (ea_eff - eb_eff);
	assign aligned = small_op >> e_diff;
	assign lost = ((aligned << e_diff) != small_op);
	assign sign_big = swap ? sb : sa;
	assign sign_small = swap ? sa : sb;
	assign total = (sign_big != sign_small) ? (big - (aligned | 96'(lost)))
		: (big + (aligned | 96'(lost)));

	// Sum and special operands.
	always_comb begin
		n_d.sign = (total == 96'd0) ? 1'b0 : sign_big;
		n_d.sig = total;
		n_d.ex = $signed({4'd0, (swap ? eb_eff : ea_eff)}) + 12'sd1;
		n_d.special = 1'b1;
		if (nan_a) begin
			n_d.spec_bits = a | trsn_pkg::FP_QUIET_BIT;
		end else if (nan_b) begin
			n_d.spec_bits = b | trsn_pkg::FP_QUIET_BIT;
		end else if (inf_a && inf_b && (sa != sb)) begin
			n_d.spec_bits = trsn_pkg::FP_DEFAULT_NAN;
		end else if (inf_a) begin
			n_d.spec_bits = a;
		end else if (inf_b) begin
			n_d.spec_bits = {sb, trsn_pkg::EXP_ALL_ONES, 23'd0};
		end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
			n_d.spec_bits = {sa & sb, 31'd0};
		end else begin
			n_d.special = 1'b0;
			n_d.spec_bits = 32'd0;
		end
	end

	// Pipeline: sum, shift count, rounded result.
	always_ff @(posedge clk) begin
		n_s1 <= n_d;
		sh_s2 <= trsn_pkg::norm_prep(n_s1);
		y_s3 <= trsn_pkg::norm_finish(sh_s2);
	end

	assign y = y_s3;

endmodule

`default_nettype wire

### rtl/trsn_checker.sv
// -----------------------------------------------------------------------------
// trsn_checker
// Port-level checks of the square root block, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none

`include "table_rsqrt_sqrt_newton_defines.svh"

module trsn_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        op,
	input wire logic [31:0] sample_bits,
	input wire logic        done,
	input wire logic [31:0] result_bits
);

	logic acc;
	logic neg;

	assign acc = start && !busy;
	assign neg = sample_bits[31] && (sample_bits[30:0] != 31'd0)
		&& ((sample_bits[30:23] != 8'hFF) || (sample_bits[22:0] == 23'd0));

	// The pipeline takes an item in every cycle.
	`TRSN_ASSERT_IMP(a_never_busy, 1'b1, !busy, "busy raised")

	// Every accepted item gives exactly one result, and no result comes without an item.
	`TRSN_ASSERT_DLY(a_result_follows, acc, trsn_pkg::LATENCY, done, "result missing")
	`TRSN_ASSERT_IMP(a_no_stray_result, done, $past(acc, trsn_pkg::LATENCY), "stray result")

	// A negative sample always yields +0.0.
	`TRSN_ASSERT_DLY(a_negative_zero, acc && neg, trsn_pkg::LATENCY,
		result_bits == 32'd0, "negative sample not zero")

endmodule

bind table_rsqrt_sqrt_newton trsn_checker u_trsn_checker (.*);

`default_nettype wire

### tb/tb_table_rsqrt_sqrt_newton.sv
// -----------------------------------------------------------------------------
// tb_table_rsqrt_sqrt_newton
// Self-checking bench for the table-guess square root block. It predicts
// every result with a bit-exact single-precision model: table lookup, one
// Newton step, round to nearest even with subnormals kept. It then compares
// each done strobe with the oldest prediction. NaN results match any NaN.
// -----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_table_rsqrt_sqrt_newton;

	localparam int N_RANDOM = 550;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        op;
	logic [31:0] sample_bits;
	logic        done;
	logic [31:0] result_bits;

	logic [31:0] exp_table [256];
	logic [31:0] mant_table [1024];

	table_rsqrt_sqrt_newton u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.sample_bits(sample_bits),
		.done       (done),
		.result_bits(result_bits)
	);

	// Any quiet NaN stands for a NaN result of an operation.
	localparam logic [31:0] QNAN = 32'h7FC0_0000;

	function automatic logic is_nan(logic [31:0] x);
		return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(logic [31:0] x);
		return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
	endfunction

	// Rounds s * m * 2^e to single precision, nearest even, subnormals kept.
	function automatic logic [31:0] fp_round(logic s, int e, logic [127:0] m);
		int           msb;
		int           biased;
		int           sh;
		logic [127:0] q;
		logic         grd;
		logic         stk;
		longint       val;
		if (m == '0) begin
			return {s, 31'd0};
		end
		msb = 0;
		for (int i = 0; i < 128; i++) begin
			if (m[i]) begin
				msb = i;
			end
		end
		biased = msb + e + 127;
		sh = (biased >= 1) ? msb - 23 : -149 - e;
		grd = 1'b0;
		stk = 1'b0;
		if (sh > 128) begin
			q = '0;
			stk = 1'b1;
		end else if (sh > 0) begin
			q = m >> sh;
			grd = m[sh - 1];
			stk = (m & ((128'd1 << (sh - 1)) - 128'd1)) != '0;
		end else begin
			q = m << (-sh);
		end
		q = q + 128'(grd & (stk | q[0]));
		if (biased >= 1) begin
			val = longint'(biased - 1) * 64'd8388608 + longint'(q[25:0]);
		end else begin
			val = longint'(q[25:0]);
		end
		if (val >= 64'h7F80_0000) begin
			return {s, 8'hFF, 23'd0};
		end
		return {s, val[30:0]};
	endfunction

	// Splits a float into significand and the exponent of its last bit.
	function automatic void fp_split(logic [31:0] x, output logic [23:0] m, output int e);
		m = {(x[30:23] != 8'd0), x[22:0]};
		e = ((x[30:23] == 8'd0) ? 1 : int'(x[30:23])) - 150;
	endfunction

	function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
		logic [23:0] ma;
		logic [23:0] mb;
		int          ea;
		int          eb;
		logic        s;
		s = a[31] ^ b[31];
		if (is_nan(a) || is_nan(b)) begin
			return QNAN;
		end
		if (is_inf(a) || is_inf(b)) begin
			if (a[30:0] == 31'd0 || b[30:0] == 31'd0) begin
				return QNAN;
			end
			return {s, 8'hFF, 23'd0};
		end
		fp_split(a, ma, ea);
		fp_split(b, mb, eb);
		return fp_round(s, ea + eb, 128'(ma) * 128'(mb));
	endfunction

	// a - b, computed as a plus b with its sign flipped.
	function automatic logic [31:0] fp_sub(logic [31:0] a, logic [31:0] b_in);
		logic [31:0]  b;
		logic [23:0]  ma;
		logic [23:0]  mb;
		int           ea;
		int           eb;
		int           emax;
		logic [127:0] wa;
		logic [127:0] wb;
		logic [127:0] mag;
		logic         s;
		b = {~b_in[31], b_in[30:0]};
		if (is_nan(a) || is_nan(b)) begin
			return QNAN;
		end
		if (is_inf(a) && is_inf(b)) begin
			return (a[31] == b[31]) ? a : QNAN;
		end
		if (is_inf(a)) begin
			return a;
		end
		if (is_inf(b)) begin
			return b;
		end
		if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
			return {a[31] & b[31], 31'd0};
		end
		fp_split(a, ma, ea);
		fp_split(b, mb, eb);
		emax = (ea > eb) ? ea : eb;
		wa = 128'(ma) << 40;
		wb = 128'(mb) << 40;
		// Align onto the larger exponent; bits shifted out leave a sticky bit.
		if (emax - ea >= 127) begin
			wa = 128'(wa != '0);
		end else if (emax != ea) begin
			wa = (wa >> (emax - ea)) | 128'(((wa >> (emax - ea)) << (emax - ea)) != wa);
		end
		if (emax - eb >= 127) begin
			wb = 128'(wb != '0);
		end else if (emax != eb) begin
			wb = (wb >> (emax - eb)) | 128'(((wb >> (emax - eb)) << (emax - eb)) != wb);
		end
		if (a[31] == b[31]) begin
			mag = wa + wb;
			s = a[31];
		end else if (wa >= wb) begin
			mag = wa - wb;
			s = a[31];
		end else begin
			mag = wb - wa;
			s = b[31];
		end
		if (mag == '0) begin
			return 32'd0;
		end
		return fp_round(s, emax - 40, mag);
	endfunction

	// Fills the exponent and mantissa lookup tables.
	task automatic build_tables();
		int          d;
		int          k;
		real         y;
		real         x;
		logic [63:0] db;
		for (int e = 0; e < 256; e++) begin
			d = ((e == 0) ? 1 : ((e == 255) ? 254 : e)) - 127;
			if (d % 2 == 0) begin
				exp_table[e] = {1'b0, 8'(127 - d / 2), 23'd0};
			end else begin
				k = (d - 1) / 2;
				exp_table[e] = {1'b0, 8'(126 - k), trsn_pkg::SQRT_HALF_MANT};
			end
		end
		for (int i = 0; i < 1024; i++) begin
			x = 1.0 + real'(i) / 1024.0;
			y = 0.85;
			for (int n = 0; n < 10; n++) begin
				y = y * (1.5 - 0.5 * x * y * y);
			end
			db = $realtobits(y);
			mant_table[i] = {1'b0, 8'(db[62:52] - 11'd896), db[51:29]}
				+ 32'(db[28] & ((|db[27:0]) | db[29]));
		end
	endtask

	// Expected result of one item.
	function automatic logic [31:0] predict_root(logic op_i, logic [31:0] f);
		logic [31:0] g;
		logic [31:0] h;
		logic [31:0] r;
		if (f[31] && !is_nan(f) && f[30:0] != 31'd0) begin
			return 32'd0;
		end
		g = fp_mul(exp_table[f[30:23]], mant_table[f[22:13]]);
		h = fp_mul(trsn_pkg::FP_HALF, g);
		h = fp_mul(h, g);
		h = fp_mul(h, g);
		h = fp_mul(h, f);
		r = fp_sub(fp_mul(trsn_pkg::FP_THREE_HALVES, g), h);
		return op_i ? fp_mul(f, r) : r;
	endfunction

	// Holds the predicted results in order and checks the strobed ones.
	class root_scoreboard;
		logic [31:0] expected_q[$];
		int          mismatches;

		function void note_item(logic op_i, logic [31:0] f);
			expected_q.push_back(predict_root(op_i, f));
		endfunction

		function void check_result(logic [31:0] got);
			logic [31:0] want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result %h", got);
				end
				return;
			end
			want = expected_q.pop_front();
			if (is_nan(want) ? !is_nan(got) : (got !== want)) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result_bits mismatch: expected %h, got %h", want, got);
				end
			end
		endfunction
	endclass

	root_scoreboard sb;
	int             burst_left;

	// Holds start with the item until an edge accepts it, then maybe pauses.
	task automatic send_item(logic op_i, logic [31:0] f);
		start <= 1'b1;
		op <= op_i;
		sample_bits <= f;
		forever begin
			@(posedge clk);
			if (!busy) begin
				break;
			end
		end
		sb.note_item(op_i, f);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 30);
			if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	// Random float sample, biased toward positive normals.
	function automatic logic [31:0] random_sample();
		logic [31:0] x;
		x = $urandom;
		case ($urandom_range(0, 9))
			0, 1: ;
			2: x[30:23] = 8'd0;
			3: x[30:23] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'hFE;
			default: begin
				x[31] = 1'b0;
				x[30:23] = 8'($urandom_range(1, 254));
			end
		endcase
		return x;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_result(result_bits);
		end
	end

	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		logic [31:0] corner [20];
		sb = new();
		build_tables();
		arst_n = 1'b0;
		start = 1'b0;
		op = 1'b0;
		sample_bits = 32'd0;
		burst_left = 0;
		corner = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
			32'h7FC0_0000, 32'hFFC0_0001, 32'h7F80_0001, 32'h0000_0001,
			32'h007F_FFFF, 32'h0080_0000, 32'h7F7F_FFFF, 32'h3F80_0000,
			32'h4080_0000, 32'h4000_0000, 32'hBF80_0000, 32'h8000_0001,
			32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h3FFF_E000, 32'h0040_0000};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed corners, alternating the two operations.
		for (int i = 0; i < 20; i++) begin
			send_item(i[0], corner[i]);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			send_item(1'($urandom), random_sample());
		end
		start <= 1'b0;
		while (sb.expected_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (trsn_pkg::LATENCY + 5) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
